// File: design/brf_pkg.sv
// Shared definitions for the byte ring FIFO: sizes, item codes and the
// command and status groups between controller and datapath.
// No dependencies.
`default_nettype none

package brf_pkg;

  // Default store size in bytes (power of two)
  localparam int DEFAULT_DEPTH = 1024;
  // Length header stored ahead of each frame
  localparam int HEADER_BYTES  = 4;
  // Index of the last header byte
  localparam logic [2:0] HDR_LAST = 3'(HEADER_BYTES - 1);
  // Header read runs one step further to collect the last registered byte
  localparam logic [2:0] HDR_DONE = 3'(HEADER_BYTES);

  // Item codes carried on the mode field
  typedef enum logic [1:0] {
    MODE_WR_REQ  = 2'd0,
    MODE_WR_BYTE = 2'd1,
    MODE_RD_REQ  = 2'd2,
    MODE_RD_BYTE = 2'd3
  } mode_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic latch_item;     // capture the accepted item, clear the result
    logic wr_req_stream;  // open a stream write transfer
    logic wr_byte;        // store one byte of an open write transfer
    logic hdr_wr;         // store one header byte, advance header index
    logic hdr_wr_commit;  // open the frame write after the last header byte
    logic rd_req_stream;  // open a stream read transfer
    logic rd_byte_issue;  // read the store at the read cursor
    logic rd_byte_finish; // take the read byte, advance the read cursor
    logic hdr_clear;      // reset the header index
    logic hdr_rd;         // issue/collect header reads, advance header index
    logic hdr_rd_commit;  // open the frame read from the collected header
    logic load_result;    // move the finished result to the output register
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    mode_t      item_mode;
    logic       frame_mode;
    logic       wr_busy;
    logic       rd_busy;
    logic       wr_grant_ok;
    logic       rd_pre_ok;
    logic       hdr_ok;
    logic [2:0] hdr_idx;
    logic       out_free;
  } status_t;

endpackage

`default_nettype wire

// File: design/brf_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none

module brf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: design/brf_ctrl.sv
// Controller state machine for the byte ring FIFO: sequences each item
// through decode, header accesses and result hand-over. Uses brf_pkg.
`default_nettype none

module brf_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire brf_pkg::status_t status,
  output brf_pkg::cmd_t         cmd
);

  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_DECODE  = 7'b0000010,
    ST_HDR_WR  = 7'b0000100,
    ST_HDR_RD  = 7'b0001000,
    ST_HDR_CHK = 7'b0010000,
    ST_RD_WAIT = 7'b0100000,
    ST_FINISH  = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  // Take a new item only when idle
  assign in_stall = (state != ST_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.latch_item = 1'b1;
          state_next     = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_next = ST_FINISH;
        case (status.item_mode)
          brf_pkg::MODE_WR_REQ: begin
            if (status.wr_grant_ok) begin
              if (status.frame_mode) begin
                cmd.hdr_clear = 1'b1;
                state_next    = ST_HDR_WR;
              end else begin
                cmd.wr_req_stream = 1'b1;
              end
            end
          end
          brf_pkg::MODE_WR_BYTE: begin
            cmd.wr_byte = status.wr_busy;
          end
          brf_pkg::MODE_RD_REQ: begin
            if (status.rd_pre_ok) begin
              if (status.frame_mode) begin
                cmd.hdr_clear = 1'b1;
                state_next    = ST_HDR_RD;
              end else begin
                cmd.rd_req_stream = 1'b1;
              end
            end
          end
          brf_pkg::MODE_RD_BYTE: begin
            if (status.rd_busy) begin
              cmd.rd_byte_issue = 1'b1;
              state_next        = ST_RD_WAIT;
            end
          end
          default: begin
            state_next = ST_FINISH;
          end
        endcase
      end
      ST_HDR_WR: begin
        cmd.hdr_wr = 1'b1;
        if (status.hdr_idx == brf_pkg::HDR_LAST) begin
          cmd.hdr_wr_commit = 1'b1;
          state_next        = ST_FINISH;
        end
      end
      ST_HDR_RD: begin
        cmd.hdr_rd = 1'b1;
        if (status.hdr_idx == brf_pkg::HDR_DONE) begin
          state_next = ST_HDR_CHK;
        end
      end
      ST_HDR_CHK: begin
        cmd.hdr_rd_commit = status.hdr_ok;
        state_next        = ST_FINISH;
      end
      ST_RD_WAIT: begin
        cmd.rd_byte_finish = 1'b1;
        state_next         = ST_FINISH;
      end
      ST_FINISH: begin
        // Hold until the output register is free
        if (status.out_free) begin
          cmd.load_result = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// File: design/brf_dpath.sv
// Datapath for the byte ring FIFO: pointers, transfer counters, grant
// arithmetic, header assembly, byte store and output register.
// Uses brf_pkg and brf_ram.
`default_nettype none

module brf_dpath #(
  parameter int DEPTH = brf_pkg::DEFAULT_DEPTH,
  localparam int AW   = $clog2(DEPTH),
  localparam int PW   = AW + 1
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire brf_pkg::cmd_t    cmd,
  output brf_pkg::status_t      status,
  input  wire logic [1:0]       mode,
  input  wire logic [7:0]       data_in,
  input  wire logic [15:0]      length,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic             cfg_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic      [PW-1:0]    granted,
  output logic      [7:0]       data_out,
  output logic                  accepted,
  output logic      [PW-1:0]    used_count,
  output logic      [PW-1:0]    free_count,
  output logic                  is_full,
  output logic                  is_empty
);

  // Width for comparing the request length against counts
  localparam int SW = ((PW > 16) ? PW : 16) + 1;
  localparam logic [PW-1:0] DEPTH_P = PW'(DEPTH);
  localparam logic [PW-1:0] HDR_P   = PW'(brf_pkg::HEADER_BYTES);

  logic                  frame_mode;
  logic [PW-1:0]         rd_ptr;
  logic [PW-1:0]         wr_ptr;
  logic [PW-1:0]         wr_left;
  logic [PW-1:0]         wr_cur;
  logic [PW-1:0]         rd_left;
  logic [PW-1:0]         rd_cur;
  brf_pkg::mode_t        item_mode;
  logic [7:0]            item_data;
  logic [15:0]           item_len;
  logic [31:0]           hdr;
  logic [2:0]            hdr_idx;
  logic [PW-1:0]         res_granted;
  logic [7:0]            res_dout;
  logic                  res_acc;

  logic [PW-1:0]         used_w;
  logic [PW-1:0]         free_w;
  logic [SW-1:0]         len_x;
  logic [PW-1:0]         wr_grant;
  logic [PW-1:0]         rd_grant;
  logic [PW-1:0]         wr_ptr_hdr;
  logic [PW-1:0]         rd_ptr_hdr;
  logic [PW-1:0]         wr_cur_inc;
  logic [PW-1:0]         rd_cur_inc;
  logic [PW-1:0]         hdr_rd_len;

  logic                  ram_wr_en;
  logic [AW-1:0]         ram_wr_addr;
  logic [7:0]            ram_wr_data;
  logic                  ram_rd_en;
  logic [AW-1:0]         ram_rd_addr;
  logic [7:0]            ram_rd_data;
  logic [7:0]            hdr_byte;

  // Committed fill and grant arithmetic
  assign used_w     = wr_ptr - rd_ptr;
  assign free_w     = DEPTH_P - used_w;
  assign len_x      = SW'(item_len);
  assign wr_grant   = (len_x < SW'(free_w)) ? PW'(item_len) : free_w;
  assign rd_grant   = (len_x < SW'(used_w)) ? PW'(item_len) : used_w;
  assign wr_ptr_hdr = wr_ptr + HDR_P;
  assign rd_ptr_hdr = rd_ptr + HDR_P;
  assign wr_cur_inc = wr_cur + PW'(1);
  assign rd_cur_inc = rd_cur + PW'(1);
  assign hdr_rd_len = hdr[PW-1:0];

  // Status towards the controller
  always_comb begin
    status.item_mode  = item_mode;
    status.frame_mode = frame_mode;
    status.wr_busy    = (wr_left != '0);
    status.rd_busy    = (rd_left != '0);
    if (frame_mode) begin
      status.wr_grant_ok = (wr_left == '0) &&
                           ((len_x + SW'(brf_pkg::HEADER_BYTES)) <= SW'(free_w));
      status.rd_pre_ok   = (rd_left == '0) && (used_w >= HDR_P);
    end else begin
      status.wr_grant_ok = (wr_left == '0) && (free_w != '0) && (item_len != '0);
      status.rd_pre_ok   = (rd_left == '0) && (used_w != '0) && (item_len != '0);
    end
    status.hdr_ok   = (hdr <= 32'(used_w - HDR_P)) && (32'(item_len) >= hdr);
    status.hdr_idx  = hdr_idx;
    status.out_free = !out_valid || !out_stall;
  end

  // Header byte to store: length little-endian, upper bytes zero
  always_comb begin
    case (hdr_idx)
      3'd0:    hdr_byte = item_len[7:0];
      3'd1:    hdr_byte = item_len[15:8];
      default: hdr_byte = 8'h00;
    endcase
  end

  // Store port selection
  assign ram_wr_en   = cmd.wr_byte || cmd.hdr_wr;
  assign ram_wr_addr = cmd.hdr_wr ? AW'(wr_ptr + PW'(hdr_idx)) : wr_cur[AW-1:0];
  assign ram_wr_data = cmd.hdr_wr ? hdr_byte : item_data;
  assign ram_rd_en   = cmd.rd_byte_issue || (cmd.hdr_rd && (hdr_idx < brf_pkg::HDR_DONE));
  assign ram_rd_addr = cmd.hdr_rd ? AW'(rd_ptr + PW'(hdr_idx)) : rd_cur[AW-1:0];

  brf_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Configuration register, always ready
  assign cfg_ready = 1'b1;

  // Pointers, transfer state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_mode <= 1'b0;
      rd_ptr     <= '0;
      wr_ptr     <= '0;
      wr_left    <= '0;
      wr_cur     <= '0;
      rd_left    <= '0;
      rd_cur     <= '0;
      hdr_idx    <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        frame_mode <= cfg_data;
      end
      if (cmd.hdr_clear) begin
        hdr_idx <= '0;
      end else if (cmd.hdr_wr || cmd.hdr_rd) begin
        hdr_idx <= hdr_idx + 3'd1;
      end
      // Write side
      if (cmd.wr_req_stream) begin
        wr_cur  <= wr_ptr;
        wr_left <= wr_grant;
      end else if (cmd.wr_byte) begin
        wr_cur  <= wr_cur_inc;
        wr_left <= wr_left - PW'(1);
        if (wr_left == PW'(1)) begin
          wr_ptr <= wr_cur_inc;
        end
      end else if (cmd.hdr_wr_commit) begin
        wr_cur  <= wr_ptr_hdr;
        wr_left <= PW'(item_len);
        if (item_len == '0) begin
          wr_ptr <= wr_ptr_hdr;
        end
      end
      // Read side
      if (cmd.rd_req_stream) begin
        rd_cur  <= rd_ptr;
        rd_left <= rd_grant;
      end else if (cmd.rd_byte_finish) begin
        rd_cur  <= rd_cur_inc;
        rd_left <= rd_left - PW'(1);
        if (rd_left == PW'(1)) begin
          rd_ptr <= rd_cur_inc;
        end
      end else if (cmd.hdr_rd_commit) begin
        rd_cur  <= rd_ptr_hdr;
        rd_left <= hdr_rd_len;
        if (hdr == '0) begin
          rd_ptr <= rd_ptr_hdr;
        end
      end
    end
  end

  // Item capture, header assembly and result build-up
  always_ff @(posedge clk) begin
    if (cmd.latch_item) begin
      item_mode   <= brf_pkg::mode_t'(mode);
      item_data   <= data_in;
      item_len    <= length;
      res_granted <= '0;
      res_dout    <= '0;
      res_acc     <= 1'b0;
    end
    if (cmd.hdr_rd) begin
      case (hdr_idx)
        3'd1:    hdr[7:0]   <= ram_rd_data;
        3'd2:    hdr[15:8]  <= ram_rd_data;
        3'd3:    hdr[23:16] <= ram_rd_data;
        3'd4:    hdr[31:24] <= ram_rd_data;
        default: hdr        <= hdr;
      endcase
    end
    if (cmd.wr_req_stream) begin
      res_granted <= wr_grant;
      res_acc     <= 1'b1;
    end
    if (cmd.rd_req_stream) begin
      res_granted <= rd_grant;
      res_acc     <= 1'b1;
    end
    if (cmd.hdr_wr_commit) begin
      res_granted <= PW'(item_len);
      res_acc     <= 1'b1;
    end
    if (cmd.hdr_rd_commit) begin
      res_granted <= hdr_rd_len;
      res_acc     <= 1'b1;
    end
    if (cmd.wr_byte) begin
      res_acc <= 1'b1;
    end
    if (cmd.rd_byte_finish) begin
      res_dout <= ram_rd_data;
      res_acc  <= 1'b1;
    end
  end

  // Output register: valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_result) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Output register: payload
  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      granted    <= res_granted;
      data_out   <= res_dout;
      accepted   <= res_acc;
      used_count <= used_w;
      free_count <= free_w;
      is_full    <= (used_w == DEPTH_P);
      is_empty   <= (used_w == '0);
    end
  end

endmodule

`default_nettype wire

// File: design/byte_ring_fifo_stream_or_frame.sv
// Top level of the byte ring FIFO with stream and length-prefixed frame modes.
// Joins brf_ctrl and brf_dpath; uses brf_pkg.
//
//   Channel  Handshake                  Payload
//   -------  -------------------------  ---------------------------------------
//   in       in_valid / in_stall        mode, data_in, length
//   out      out_valid / out_stall      granted, data_out, accepted,
//                                       used_count, free_count, is_full, is_empty
//   cfg      cfg_valid / cfg_ready      cfg_data (frame_mode)
//
// One item at a time, transfer to transfer. An accepted read byte waits for the registered
// store read; an accepted frame write request adds four header byte writes, and a frame
// read request past decode adds four header byte reads through the single read port,
// then the length check.
// Reset clears pointers, counters and mode; the store is not cleared.
// A stalled output holds its result while the next item is worked on; that result waits.
`default_nettype none

module byte_ring_fifo_stream_or_frame #(
  parameter int DEPTH = brf_pkg::DEFAULT_DEPTH,
  localparam int PW   = $clog2(DEPTH) + 1
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [1:0]    mode,
  input  wire logic [7:0]    data_in,
  input  wire logic [15:0]   length,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic      [PW-1:0] granted,
  output logic      [7:0]    data_out,
  output logic               accepted,
  output logic      [PW-1:0] used_count,
  output logic      [PW-1:0] free_count,
  output logic               is_full,
  output logic               is_empty,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic          cfg_data
);

  brf_pkg::cmd_t    cmd;
  brf_pkg::status_t status;

  // Sequencer
  brf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Pointers, store and result
  brf_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .mode       (mode),
    .data_in    (data_in),
    .length     (length),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .granted    (granted),
    .data_out   (data_out),
    .accepted   (accepted),
    .used_count (used_count),
    .free_count (free_count),
    .is_full    (is_full),
    .is_empty   (is_empty)
  );

endmodule

`default_nettype wire

// File: tb/ring_fifo_checker.sv
// Checker for the byte ring FIFO: mirrors the pointers, open transfers and the
// byte store, predicts the reply to every item and compares it field by field.
// Depends on brf_pkg.
`timescale 1ns / 1ps

module ring_fifo_checker #(
  parameter int DEPTH = brf_pkg::DEFAULT_DEPTH,
  localparam int PW   = $clog2(DEPTH) + 1
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire logic          in_stall,
  input  wire logic [1:0]    mode,
  input  wire logic [7:0]    data_in,
  input  wire logic [15:0]   length,
  input  wire logic          out_valid,
  input  wire logic          out_stall,
  input  wire logic [PW-1:0] granted,
  input  wire logic [7:0]    data_out,
  input  wire logic          accepted,
  input  wire logic [PW-1:0] used_count,
  input  wire logic [PW-1:0] free_count,
  input  wire logic          is_full,
  input  wire logic          is_empty,
  input  wire logic          cfg_valid,
  input  wire logic          cfg_ready,
  input  wire logic          cfg_data,
  output int                 mismatches,
  output int                 outstanding,
  output int                 held_bytes
);

  typedef struct packed {
    logic [PW-1:0] granted;
    logic [7:0]    data_out;
    logic          accepted;
    logic [PW-1:0] used;
    logic [PW-1:0] free;
    logic          full;
    logic          empty;
  } fifo_reply_t;

  // Mirror of the store; entries stay unknown until written
  logic [7:0]    shadow_store [DEPTH];
  logic [PW-1:0] rd_ptr, wr_ptr, wr_left, wr_cur, rd_left, rd_cur;
  logic          frame_on;
  fifo_reply_t   awaited_replies [$];
  fifo_reply_t   want;

  function automatic logic [PW-1:0] occupancy();
    return wr_ptr - rd_ptr;
  endfunction

  function automatic void store_byte(input logic [PW-1:0] at, input logic [7:0] v);
    shadow_store[at[PW-2:0]] = v;
  endfunction

  function automatic logic [7:0] load_byte(input logic [PW-1:0] at);
    return shadow_store[at[PW-2:0]];
  endfunction

  // Apply one item to the mirrored FIFO and return the reply it must produce
  function automatic fifo_reply_t apply_fifo_item(input brf_pkg::mode_t item_mode,
                                                  input logic [7:0] byte_in,
                                                  input logic [15:0] req_len);
    fifo_reply_t   r;
    int            used_b;
    int            free_b;
    int            grant;
    logic [31:0]   hdr;
    logic [PW-1:0] u;
    r      = '0;
    used_b = int'(occupancy());
    free_b = DEPTH - used_b;
    case (item_mode)
      brf_pkg::MODE_WR_REQ: begin
        if (wr_left == '0) begin
          if (frame_on) begin
            // whole frame or nothing; length header goes in little-endian, byte by byte
            if (int'(req_len) + brf_pkg::HEADER_BYTES <= free_b) begin
              for (int k = 0; k < brf_pkg::HEADER_BYTES; k++)
                store_byte(wr_ptr + PW'(k), (k < 2) ? 8'(req_len >> (8 * k)) : 8'h00);
              wr_cur  = wr_ptr + PW'(brf_pkg::HEADER_BYTES);
              wr_left = req_len[PW-1:0];
              if (req_len == '0) wr_ptr = wr_cur;
              r.accepted = 1'b1;
              r.granted  = req_len[PW-1:0];
            end
          end else if (free_b != 0 && req_len != '0) begin
            grant      = (int'(req_len) > free_b) ? free_b : int'(req_len);
            wr_cur     = wr_ptr;
            wr_left    = grant[PW-1:0];
            r.accepted = 1'b1;
            r.granted  = grant[PW-1:0];
          end
        end
      end
      brf_pkg::MODE_WR_BYTE: begin
        if (wr_left != '0) begin
          store_byte(wr_cur, byte_in);
          wr_cur  = wr_cur + 1'b1;
          wr_left = wr_left - 1'b1;
          if (wr_left == '0) wr_ptr = wr_cur;
          r.accepted = 1'b1;
        end
      end
      brf_pkg::MODE_RD_REQ: begin
        if (rd_left == '0 && used_b != 0) begin
          if (frame_on) begin
            // refuse a short store, an impossible header or a caller too small
            if (used_b >= brf_pkg::HEADER_BYTES) begin
              hdr = {load_byte(rd_ptr + PW'(3)), load_byte(rd_ptr + PW'(2)),
                     load_byte(rd_ptr + PW'(1)), load_byte(rd_ptr)};
              if (hdr <= 32'(used_b - brf_pkg::HEADER_BYTES) && hdr <= 32'(req_len)) begin
                rd_cur  = rd_ptr + PW'(brf_pkg::HEADER_BYTES);
                rd_left = hdr[PW-1:0];
                if (hdr == '0) rd_ptr = rd_cur;
                r.accepted = 1'b1;
                r.granted  = hdr[PW-1:0];
              end
            end
          end else if (req_len != '0) begin
            grant      = (int'(req_len) > used_b) ? used_b : int'(req_len);
            rd_cur     = rd_ptr;
            rd_left    = grant[PW-1:0];
            r.accepted = 1'b1;
            r.granted  = grant[PW-1:0];
          end
        end
      end
      default: begin
        if (rd_left != '0) begin
          r.data_out = load_byte(rd_cur);
          rd_cur  = rd_cur + 1'b1;
          rd_left = rd_left - 1'b1;
          if (rd_left == '0) rd_ptr = rd_cur;
          r.accepted = 1'b1;
        end
      end
    endcase
    u       = occupancy();
    r.used  = u;
    r.free  = PW'(DEPTH) - u;
    r.full  = (u == PW'(DEPTH));
    r.empty = (u == '0);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] exp_v,
                                 input logic [31:0] got_v);
    mismatches++;
    $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, exp_v, got_v);
  endtask

  // Track register writes, check replies, predict each accepted item
  always @(posedge clk) begin
    if (rst) begin
      rd_ptr      = '0;
      wr_ptr      = '0;
      wr_left     = '0;
      wr_cur      = '0;
      rd_left     = '0;
      rd_cur      = '0;
      frame_on    = 1'b0;
      mismatches  = 0;
      awaited_replies.delete();
    end else begin
      if (cfg_valid && cfg_ready) frame_on = cfg_data;
      if (out_valid && !out_stall) begin
        if (awaited_replies.size() == 0) begin
          report_mismatch("unexpected reply transfer", 32'd0, 32'd0);
        end else begin
          want = awaited_replies.pop_front();
          if (granted !== want.granted)
            report_mismatch("granted", 32'(want.granted), 32'(granted));
          if (data_out !== want.data_out)
            report_mismatch("data_out", 32'(want.data_out), 32'(data_out));
          if (accepted !== want.accepted)
            report_mismatch("accepted", 32'(want.accepted), 32'(accepted));
          if (used_count !== want.used)
            report_mismatch("used_count", 32'(want.used), 32'(used_count));
          if (free_count !== want.free)
            report_mismatch("free_count", 32'(want.free), 32'(free_count));
          if (is_full !== want.full)
            report_mismatch("is_full", 32'(want.full), 32'(is_full));
          if (is_empty !== want.empty)
            report_mismatch("is_empty", 32'(want.empty), 32'(is_empty));
        end
      end
      if (in_valid && !in_stall)
        awaited_replies.push_back(apply_fifo_item(brf_pkg::mode_t'(mode), data_in, length));
    end
    outstanding = awaited_replies.size();
    held_bytes  = int'(occupancy());
  end

endmodule

// File: tb/tb.sv
// Testbench top for the byte ring FIFO: drives items and frame_mode writes,
// shapes back-pressure on the reply side and gives the verdict.
// Depends on brf_pkg, ring_fifo_checker and the block itself.
`timescale 1ns / 1ps

module tb;

  localparam int DEPTH       = brf_pkg::DEFAULT_DEPTH;
  localparam int PW          = $clog2(DEPTH) + 1;
  localparam int LONG_HOLD   = 300;
  localparam int SETTLE      = 30;
  localparam int PHASE_ITEMS = 36;

  logic           clk       = 1'b0;
  logic           rst       = 1'b1;
  logic           in_valid  = 1'b0;
  logic           in_stall;
  brf_pkg::mode_t mode      = brf_pkg::MODE_WR_REQ;
  logic [7:0]     data_in   = '0;
  logic [15:0]    length    = '0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  logic [PW-1:0]  granted, used_count, free_count;
  logic [7:0]     data_out;
  logic           accepted, is_full, is_empty;
  logic           cfg_valid = 1'b0;
  logic           cfg_ready;
  logic           cfg_data  = 1'b0;

  int mismatches, outstanding, held_bytes;
  bit calm      = 1'b0;
  bit want_hold = 1'b0;
  int items_sent = 0;
  int frame_lens [$];

  always #6 clk = ~clk;

  byte_ring_fifo_stream_or_frame #(.DEPTH(DEPTH)) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .data_in(data_in), .length(length),
    .out_valid(out_valid), .out_stall(out_stall),
    .granted(granted), .data_out(data_out), .accepted(accepted),
    .used_count(used_count), .free_count(free_count),
    .is_full(is_full), .is_empty(is_empty),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  ring_fifo_checker #(.DEPTH(DEPTH)) watcher (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .data_in(data_in), .length(length),
    .out_valid(out_valid), .out_stall(out_stall),
    .granted(granted), .data_out(data_out), .accepted(accepted),
    .used_count(used_count), .free_count(free_count),
    .is_full(is_full), .is_empty(is_empty),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .mismatches(mismatches), .outstanding(outstanding), .held_bytes(held_bytes)
  );

  // Offer one item, with an occasional idle burst ahead of it; hold until the transfer
  task automatic offer(input brf_pkg::mode_t m, input logic [7:0] d, input logic [15:0] count);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode     <= m;
    data_in  <= d;
    length   <= count;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Drop valid and wait until every reply is in and the block has gone quiet
  task automatic wait_idle();
    int guard;
    in_valid <= 1'b0;
    @(posedge clk);
    guard = 0;
    while (outstanding != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_frame_mode(input logic framed);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= framed;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    frame_lens.delete();
  endtask

  // Write request for req bytes, then n byte items (fill below zero means random data)
  task automatic write_burst(input int req, input int n, input int fill);
    offer(brf_pkg::MODE_WR_REQ, 8'($urandom), 16'(req));
    for (int k = 0; k < n; k++)
      offer(brf_pkg::MODE_WR_BYTE, (fill < 0) ? 8'($urandom) : 8'(fill), 16'($urandom));
  endtask

  task automatic read_burst(input int req, input int n);
    offer(brf_pkg::MODE_RD_REQ, 8'($urandom), 16'(req));
    repeat (n) offer(brf_pkg::MODE_RD_BYTE, 8'($urandom), 16'($urandom));
  endtask

  // One random sequence: mostly whole transfers, some cut short, some lone items
  task automatic random_step(input bit framed);
    int pick;
    int n;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      if (framed && $urandom_range(0, 19) == 0) begin
        offer(brf_pkg::MODE_WR_REQ, 8'($urandom), 16'($urandom_range(1021, 65535)));
      end else begin
        n = framed ? $urandom_range(0, 24) : $urandom_range(1, 32);
        if (framed) frame_lens.push_back(n);
        write_burst(n, n, -1);
      end
    end else if (pick < 80) begin
      if (framed && frame_lens.size() > 0 && frame_lens[0] > 0
          && $urandom_range(0, 9) == 0) begin
        read_burst(frame_lens[0] - 1, 1);
      end else if (framed) begin
        n = (frame_lens.size() > 0) ? frame_lens.pop_front() : $urandom_range(0, 24);
        read_burst(n + $urandom_range(0, 3), n);
      end else begin
        n = $urandom_range(1, 32);
        read_burst(n, n);
      end
    end else if (pick < 90) begin
      n = $urandom_range(2, 16);
      if ($urandom_range(0, 1)) write_burst(n, $urandom_range(0, n - 1), -1);
      else read_burst(n, $urandom_range(0, n - 1));
    end else begin
      offer(brf_pkg::mode_t'($urandom_range(0, 3)), 8'($urandom),
            16'($urandom_range(0, 40)));
    end
  endtask

  // Reply side: random stall bursts, one long hold-off on request, none at the end
  initial begin
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (want_hold) begin
        want_hold = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  initial begin
    int phase_end;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    set_frame_mode(1'b0);

    // Stream refusals: empty read, bytes with no grant, zero length
    offer(brf_pkg::MODE_RD_REQ, 8'h00, 16'd5);
    offer(brf_pkg::MODE_RD_BYTE, 8'h00, 16'd0);
    offer(brf_pkg::MODE_WR_BYTE, 8'hFF, 16'hFFFF);
    offer(brf_pkg::MODE_WR_REQ, 8'h00, 16'd0);
    // Uncommitted bytes are not readable; a second request while busy is refused
    write_burst(10, 4, -1);
    offer(brf_pkg::MODE_RD_REQ, 8'h5A, 16'd3);
    offer(brf_pkg::MODE_WR_REQ, 8'hA5, 16'd2);
    repeat (6) offer(brf_pkg::MODE_WR_BYTE, 8'($urandom), 16'($urandom));
    // Read asks for more than is held, then a busy read request, then one byte too many
    read_burst(20, 2);
    offer(brf_pkg::MODE_RD_REQ, 8'h00, 16'd1);
    repeat (9) offer(brf_pkg::MODE_RD_BYTE, 8'h00, 16'd0);

    // Frame mode: empty frames, frames too big, empty read, caller too small
    set_frame_mode(1'b1);
    offer(brf_pkg::MODE_WR_REQ, 8'h00, 16'd0);
    offer(brf_pkg::MODE_RD_REQ, 8'h00, 16'd0);
    offer(brf_pkg::MODE_WR_REQ, 8'h00, 16'd1021);
    offer(brf_pkg::MODE_WR_REQ, 8'h00, 16'h8000);
    offer(brf_pkg::MODE_RD_REQ, 8'h00, 16'd5);
    write_burst(3, 3, -1);
    offer(brf_pkg::MODE_RD_REQ, 8'h00, 16'd2);
    read_burst(3, 4);

    // Stream bytes read as a frame: too few for a header, then an impossible header
    set_frame_mode(1'b0);
    write_burst(2, 2, 8'hFF);
    set_frame_mode(1'b1);
    offer(brf_pkg::MODE_RD_REQ, 8'h00, 16'd100);
    set_frame_mode(1'b0);
    write_burst(6, 6, 8'hFF);
    set_frame_mode(1'b1);
    offer(brf_pkg::MODE_RD_REQ, 8'h00, 16'hFFFF);
    set_frame_mode(1'b0);
    read_burst(8, 8);

    // Random phases, alternating the mode; the last one runs without idling
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 7) calm = 1'b1;
      set_frame_mode(ph[0]);
      if (ph == 3) want_hold = 1'b1;
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) random_step(ph[0]);
      if (!ph[0] && $urandom_range(0, 1)) begin
        wait_idle();
        if (held_bytes > 0) read_burst(held_bytes, held_bytes);
      end
    end

    wait_idle();
    if (mismatches == 0 && outstanding == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

// File: filelist.f
design/brf_pkg.sv
design/brf_ram.sv
design/brf_ctrl.sv
design/brf_dpath.sv
design/byte_ring_fifo_stream_or_frame.sv
tb/ring_fifo_checker.sv
tb/tb.sv
